// ----- sv/shared_pool_multi_stack_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the shared-pool multi-stack unit
// Implication forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_STACK_UNIT_ASSERT_SVH
`define SHARED_POOL_MULTI_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SMSU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smsu check failed");

// Next-cycle implication, disabled while reset is asserted
`define SMSU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smsu check failed");

`endif

// ----- sv/smsu_pkg.sv -----
// ----------------------------------------------------------------------------
// smsu_pkg
// Sizes, codes and shared types of the shared-pool multi-stack unit.
// ----------------------------------------------------------------------------
package smsu_pkg;

	localparam int NUM_STACKS = 8;
	localparam int POOL_DEPTH = 256;
	localparam int DATA_WIDTH = 32;

	// field widths of the beat
	localparam int SID_W    = 3;
	localparam int DIN_W    = 32;
	localparam int STATUS_W = 2;

	// slot pointers carry one extra code for null
	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int PTR_W = $clog2(POOL_DEPTH + 1);
	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_DEPTH);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// pointer update applied when a request completes
	typedef struct packed {
		logic             push_ok;
		logic             pop_ok;
		logic [SID_W-1:0] sid;
		logic [PTR_W-1:0] idx;
		logic [PTR_W-1:0] link_val;
	} ptr_upd_t;

	// pointer state seen by the controller
	typedef struct packed {
		logic [PTR_W-1:0] free_head;
		logic [PTR_W-1:0] fresh;
		logic [PTR_W-1:0] top_rd;
	} ptr_view_t;

endpackage

// ----- sv/smsu_ram.sv -----
// ----------------------------------------------------------------------------
// smsu_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port, holds its word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/smsu_ptrs.sv -----
// ----------------------------------------------------------------------------
// smsu_ptrs
// Stack top pointers, free-list head and the fill mark of the link memory.
// ----------------------------------------------------------------------------
module smsu_ptrs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [smsu_pkg::SID_W-1:0] lookup_sid,
	input  smsu_pkg::ptr_upd_t         upd,
	output smsu_pkg::ptr_view_t        view
);

	import smsu_pkg::*;

	logic [PTR_W-1:0] top_q [NUM_STACKS];
	logic [PTR_W-1:0] free_head_q;
	logic [PTR_W-1:0] fresh_q;
	logic             lookup_ok;

	// look up the addressed stack; stacks beyond the count read as empty
	assign lookup_ok = (int'(lookup_sid) < NUM_STACKS);

	always_comb begin
		view.free_head = free_head_q;
		view.fresh     = fresh_q;
		view.top_rd    = lookup_ok ? top_q[lookup_sid] : NULL_PTR;
	end

	// advance the pointers on a completed push or pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				top_q[i] <= NULL_PTR;
			end
			free_head_q <= '0;
			fresh_q     <= '0;
		end else if (upd.push_ok) begin
			free_head_q     <= upd.link_val;
			top_q[upd.sid] <= upd.idx;
			if (upd.idx == fresh_q) begin
				fresh_q <= fresh_q + PTR_W'(1);
			end
		end else if (upd.pop_ok) begin
			top_q[upd.sid] <= upd.link_val;
			free_head_q     <= upd.idx;
		end
	end

endmodule

// ----- sv/shared_pool_multi_stack_unit.sv -----
// An accepted beat is captured in the s1 registers; its result then goes to the result register,
// which must first be free or drain (out_ready high). One request in flight: in_ready is low until it completes.
// The result register lets the next request in while a finished result waits.
// Reset clears stack tops to empty, the free head to slot 0 and the link fill mark.
// Links of slots never written read as the next slot; the data memory is not reset.
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_unit
// Several LIFO stacks sharing one pool of linked slots with a free list.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [smsu_pkg::SID_W-1:0]    stack_id,
	input  logic [smsu_pkg::DIN_W-1:0]    data_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [smsu_pkg::STATUS_W-1:0] status,
	output logic [smsu_pkg::DIN_W-1:0]    data_out
);

	import smsu_pkg::*;

	logic                  accept;
	logic                  complete;
	logic                  sid_ok;
	logic                  fail_in;
	logic [PTR_W-1:0]      idx_in;
	ptr_view_t             view;
	ptr_upd_t              upd;

	logic                  busy_q;
	op_t                   op_s1;
	logic [SID_W-1:0]      sid_s1;
	logic [DATA_WIDTH-1:0] din_s1;
	logic [PTR_W-1:0]      idx_s1;
	logic [PTR_W-1:0]      top_s1;
	logic                  fail_s1;
	logic                  fresh_s1;

	logic [PTR_W-1:0]      link_rd;
	logic [PTR_W-1:0]      link_val;
	logic [DATA_WIDTH-1:0] data_rd;
	logic                  push_ok;
	logic                  pop_ok;
	logic                  link_we;
	logic [PTR_W-1:0]      link_wdata;

	logic                  out_valid_q;
	status_t               status_q;
	logic [DIN_W-1:0]      data_out_q;

	// take a beat only when no request is in flight
	assign in_ready = !busy_q;
	assign accept   = in_valid && in_ready;
	assign sid_ok   = (int'(stack_id) < NUM_STACKS);

	// pick the slot: free head for a push, stack top for a pop
	assign idx_in  = (op_t'(operation) == OP_PUSH) ? view.free_head : view.top_rd;
	assign fail_in = !sid_ok || (idx_in == NULL_PTR);

	smsu_ptrs u_ptrs (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_sid (stack_id),
		.upd        (upd),
		.view       (view)
	);

	// capture the request and the pointers it needs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (complete) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(operation);
			sid_s1   <= stack_id;
			din_s1   <= DATA_WIDTH'(data_in);
			idx_s1   <= idx_in;
			top_s1   <= view.top_rd;
			fail_s1  <= fail_in;
			fresh_s1 <= (idx_in == view.fresh);
		end
	end

	// link memory: read at the chosen slot, written back when a request completes without failing
	smsu_ram #(
		.WIDTH (PTR_W),
		.DEPTH (POOL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (idx_s1[IDX_W-1:0]),
		.wdata (link_wdata),
		.re    (accept && !fail_in),
		.raddr (idx_in[IDX_W-1:0]),
		.rdata (link_rd)
	);

	// data memory: read for pops, written by pushes
	smsu_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (POOL_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (idx_s1[IDX_W-1:0]),
		.wdata (din_s1),
		.re    (accept && (op_t'(operation) == OP_POP) && !fail_in),
		.raddr (idx_in[IDX_W-1:0]),
		.rdata (data_rd)
	);

	// finish when the result register is free or drains this cycle
	assign complete = busy_q && (!out_valid_q || out_ready);
	assign push_ok  = complete && (op_s1 == OP_PUSH) && !fail_s1;
	assign pop_ok   = complete && (op_s1 == OP_POP) && !fail_s1;

	// a slot at the fill mark was never linked and points to its successor
	assign link_val   = fresh_s1 ? (idx_s1 + PTR_W'(1)) : link_rd;
	assign link_we    = push_ok || pop_ok;
	assign link_wdata = push_ok ? top_s1 : view.free_head;

	always_comb begin
		upd.push_ok  = push_ok;
		upd.pop_ok   = pop_ok;
		upd.sid      = sid_s1;
		upd.idx      = idx_s1;
		upd.link_val = link_val;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (complete) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			if (!fail_s1) begin
				status_q <= ST_OK;
			end else if (op_s1 == OP_PUSH) begin
				status_q <= ST_OVERFLOW;
			end else begin
				status_q <= ST_UNDERFLOW;
			end
			data_out_q <= pop_ok ? DIN_W'(data_rd) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data_out  = data_out_q;

endmodule

// ----- sv/smsu_checker.sv -----
// ----------------------------------------------------------------------------
// smsu_checker
// Port-level checks of the shared-pool multi-stack unit, bound to the top.
// ----------------------------------------------------------------------------
`include "shared_pool_multi_stack_unit_assert.svh"

module smsu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [smsu_pkg::STATUS_W-1:0] status,
	input logic [smsu_pkg::DIN_W-1:0]    data_out
);

	import smsu_pkg::*;

	// a stalled result beat holds its payload
	`SMSU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(data_out))

	// one request in flight: no beat right after an accepted one
	`SMSU_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)

	// only defined status codes leave the block
	`SMSU_ASSERT_NOW(a_status_code, clk, arst_n, out_valid, status == ST_OK || status == ST_OVERFLOW || status == ST_UNDERFLOW)

	// failed requests carry zero data
	`SMSU_ASSERT_NOW(a_fail_zero, clk, arst_n, out_valid && (status != ST_OK), data_out == '0)

endmodule

bind shared_pool_multi_stack_unit smsu_checker u_smsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.data_out  (data_out)
);
